### rtl/gdu_pkg.sv
// ----------------------------------------------------------------------------
// gdu_pkg
// Shared types and constants for the G.711 decoder with 2x upsampling filter.
// ----------------------------------------------------------------------------
package gdu_pkg;

	// Linear PCM sample, two's complement
	typedef logic signed [15:0] sample_t;

	// G.711 code byte
	typedef logic [7:0] code_t;

	// Filter coefficient, unsigned fixed point
	typedef logic [15:0] coef_t;

	// Configuration register indexes
	localparam logic [1:0] REG_LAW_SELECT  = 2'd0;
	localparam logic [1:0] REG_RATE_MODE   = 2'd1;
	localparam logic [1:0] REG_FILTER_COEF = 2'd2;

	// Law codes
	localparam logic LAW_MU = 1'b0;
	localparam logic LAW_A  = 1'b1;

	// Rate codes
	localparam logic RATE_PASS   = 1'b0;
	localparam logic RATE_DOUBLE = 1'b1;

	// Reset value of the filter coefficient (one half at 15 fraction bits)
	localparam coef_t COEF_RESET = 16'd16384;

	// Control from the sequencer to the filter unit
	typedef struct packed {
		logic mul;          // register the product for the current target
		logic commit;       // fold the registered product into the accumulator
		logic zero_target;  // target is zero instead of twice the sample
	} filt_ctrl_t;

endpackage

### rtl/gdu_decode.sv
// ----------------------------------------------------------------------------
// gdu_decode
// Expands one G.711 code byte to a 16-bit linear sample (mu-law or A-law).
// ----------------------------------------------------------------------------
module gdu_decode (
	input  gdu_pkg::code_t   code,
	input  logic             law,
	output gdu_pkg::sample_t sample
);

	// Segment base magnitudes for mu-law
	localparam logic [14:0] MU_BASE [8] = '{
		15'd0, 15'd132, 15'd396, 15'd924, 15'd1980, 15'd4092, 15'd8316, 15'd16764
	};
	localparam logic [7:0] A_TOGGLE = 8'h55;

	logic [7:0]  mu_u;
	logic [2:0]  mu_exp;
	logic [3:0]  mu_mant;
	logic [14:0] mu_mag;
	logic [7:0]  a_x;
	logic [2:0]  a_seg;
	logic [15:0] a_base;
	logic [15:0] a_mag;
	gdu_pkg::sample_t mu_sample;
	gdu_pkg::sample_t a_sample;

	// Mu-law: invert, then base of segment plus shifted mantissa
	always_comb begin
		mu_u      = ~code;
		mu_exp    = mu_u[6:4];
		mu_mant   = mu_u[3:0];
		mu_mag    = MU_BASE[mu_exp] + ({11'd0, mu_mant} << ({1'b0, mu_exp} + 4'd3));
		mu_sample = mu_u[7] ? -$signed({1'b0, mu_mag}) : $signed({1'b0, mu_mag});
	end

	// A-law: toggle even bits, then segment-scaled mantissa; set sign bit means positive
	always_comb begin
		a_x    = code ^ A_TOGGLE;
		a_seg  = a_x[6:4];
		a_base = {8'd0, a_x[3:0], 4'd0};
		if (a_seg == 3'd0) begin
			a_mag = a_base + 16'd8;
		end else begin
			a_mag = (a_base + 16'h0108) << (a_seg - 3'd1);
		end
		a_sample = a_x[7] ? $signed(a_mag) : -$signed(a_mag);
	end

	assign sample = (law == gdu_pkg::LAW_A) ? a_sample : mu_sample;

endmodule

### rtl/gdu_filter.sv
// ----------------------------------------------------------------------------
// gdu_filter
// One-pole low-pass: acc += trunc((target - acc) * coef / 2^F), saturated.
// Each step has a multiply phase into a product register, then an accumulate phase.
// ----------------------------------------------------------------------------
module gdu_filter #(
	parameter int COEF_FRAC_BITS = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gdu_pkg::filt_ctrl_t ctrl,
	input  gdu_pkg::sample_t    sample,
	input  gdu_pkg::coef_t      coef,
	output gdu_pkg::sample_t    y
);

	localparam int F  = COEF_FRAC_BITS;
	localparam int TW = 17;                 // twice a 16-bit sample
	localparam int AW = 19 + F;             // accumulator
	localparam int DW = AW + 1;             // target minus accumulator
	localparam int PW = DW + 17;            // product with zero-extended coefficient
	localparam int QW = PW - F;             // scaled product
	localparam int SW = ((AW > QW) ? AW : QW) + 1;
	localparam int YW = AW - F;             // integer part of the accumulator

	localparam logic [PW-1:0] PROD_BIAS = {{(PW-F){1'b0}}, {F{1'b1}}};
	localparam logic [AW-1:0] ACC_BIAS  = {{(AW-F){1'b0}}, {F{1'b1}}};
	localparam logic signed [SW-1:0] ACC_MAX = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [SW-1:0] ACC_MIN = {{(SW-AW+1){1'b1}}, {(AW-1){1'b0}}};
	localparam logic signed [YW-1:0] Y_MAX = {{(YW-15){1'b0}}, {15{1'b1}}};
	localparam logic signed [YW-1:0] Y_MIN = {{(YW-15){1'b1}}, {15{1'b0}}};

	logic signed [TW-1:0] target;
	logic signed [AW-1:0] target_fx;
	logic signed [DW-1:0] diff;
	logic signed [16:0]   coef_s;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] prod_adj;
	logic signed [PW-1:0] prod_shr;
	logic signed [QW-1:0] quot;
	logic signed [SW-1:0] sum;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] acc_next;
	logic signed [AW-1:0] acc_adj;
	logic signed [AW-1:0] acc_shr;
	logic signed [YW-1:0] y_wide;

	// Multiply stage: difference between the scaled target and the accumulator
	always_comb begin
		target    = ctrl.zero_target ? '0 : $signed({sample, 1'b0});
		target_fx = $signed({{(AW-TW-F){target[TW-1]}}, target, {F{1'b0}}});
		diff      = $signed({target_fx[AW-1], target_fx}) - $signed({acc_q[AW-1], acc_q});
		coef_s    = $signed({1'b0, coef});
		prod      = diff * coef_s;
	end

	// Hold the product for the accumulate stage
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= prod;
		end
	end

	// Accumulate stage: scale toward zero, add, saturate
	always_comb begin
		prod_adj = prod_q + (prod_q[PW-1] ? $signed(PROD_BIAS) : $signed({PW{1'b0}}));
		prod_shr = prod_adj >>> F;
		quot     = prod_shr[QW-1:0];
		sum      = $signed({{(SW-AW){acc_q[AW-1]}}, acc_q})
		         + $signed({{(SW-QW){quot[QW-1]}}, quot});
		if (sum > ACC_MAX) begin
			acc_next = ACC_MAX[AW-1:0];
		end else if (sum < ACC_MIN) begin
			acc_next = ACC_MIN[AW-1:0];
		end else begin
			acc_next = sum[AW-1:0];
		end
	end

	// Output: integer part toward zero, saturated to 16 bits
	always_comb begin
		acc_adj  = acc_next + (acc_next[AW-1] ? $signed(ACC_BIAS) : $signed({AW{1'b0}}));
		acc_shr  = acc_adj >>> F;
		y_wide   = acc_shr[YW-1:0];
		if (y_wide > Y_MAX) begin
			y = 16'sh7FFF;
		end else if (y_wide < Y_MIN) begin
			y = -16'sh8000;
		end else begin
			y = y_wide[15:0];
		end
	end

	// Accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.commit) begin
			acc_q <= acc_next;
		end
	end

endmodule

### rtl/g711_decode_upsample_filter.sv
// ----------------------------------------------------------------------------
// g711_decode_upsample_filter
// G.711 mu-law / A-law decoder with optional 2x upsampling low-pass filter.
// ----------------------------------------------------------------------------
// Each accepted code byte is decoded into an input register. In pass-through
// mode it leaves as one sample and a byte can be taken every cycle while the
// output side does not stall. In double-rate mode the byte yields two filtered
// samples (tlast on the second), each through a multiply and then an accumulate
// phase of the single filter unit; an accumulate phase waits for a free output
// register. The output register lets the next byte be taken while a sample
// still waits on the master side. Configuration is expected to change only
// while the block is idle.
module g711_decode_upsample_filter #(
	parameter int COEF_FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] code_byte
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] pcm_sample (signed)
	output logic        m_tlast,    // last_of_item
	// Configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// Filter sequencer phases
	localparam logic [1:0] PH_MUL0 = 2'd0;
	localparam logic [1:0] PH_ADD0 = 2'd1;
	localparam logic [1:0] PH_MUL1 = 2'd2;
	localparam logic [1:0] PH_ADD1 = 2'd3;

	logic                  law_q;
	logic                  rate_q;
	gdu_pkg::coef_t        coef_q;

	gdu_pkg::sample_t      dec_sample;
	gdu_pkg::sample_t      sample_s1;
	logic                  valid_s1;
	logic [1:0]            ph_q;
	logic [1:0]            ph_next;

	gdu_pkg::filt_ctrl_t   fctrl;
	gdu_pkg::sample_t      filt_y;

	logic                  out_valid_q;
	gdu_pkg::sample_t      out_data_q;
	logic                  out_last_q;
	logic                  out_free;
	logic                  out_load;
	gdu_pkg::sample_t      out_data_d;
	logic                  out_last_d;
	logic                  item_done;
	logic                  in_xfer;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			law_q  <= gdu_pkg::LAW_MU;
			rate_q <= gdu_pkg::RATE_PASS;
			coef_q <= gdu_pkg::COEF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gdu_pkg::REG_LAW_SELECT:  law_q  <= cfg_wdata[0];
				gdu_pkg::REG_RATE_MODE:   rate_q <= cfg_wdata[0];
				gdu_pkg::REG_FILTER_COEF: coef_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Decode ahead of the input register
	gdu_decode u_decode (
		.code   (s_tdata),
		.law    (law_q),
		.sample (dec_sample)
	);

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || item_done;
	assign in_xfer  = s_tvalid && s_tready;

	// Sequence the filter and pick the next output
	always_comb begin
		fctrl      = '0;
		ph_next    = ph_q;
		item_done  = 1'b0;
		out_load   = 1'b0;
		out_data_d = sample_s1;
		out_last_d = 1'b1;
		if (valid_s1) begin
			if (rate_q == gdu_pkg::RATE_PASS) begin
				out_load  = out_free;
				item_done = out_free;
			end else begin
				case (ph_q)
					PH_MUL0: begin
						fctrl.mul = 1'b1;
						ph_next   = PH_ADD0;
					end
					PH_ADD0: begin
						if (out_free) begin
							fctrl.commit = 1'b1;
							out_load     = 1'b1;
							out_data_d   = filt_y;
							out_last_d   = 1'b0;
							ph_next      = PH_MUL1;
						end
					end
					PH_MUL1: begin
						fctrl.mul         = 1'b1;
						fctrl.zero_target = 1'b1;
						ph_next           = PH_ADD1;
					end
					PH_ADD1: begin
						if (out_free) begin
							fctrl.commit = 1'b1;
							out_load     = 1'b1;
							out_data_d   = filt_y;
							out_last_d   = 1'b1;
							item_done    = 1'b1;
							ph_next      = PH_MUL0;
						end
					end
					default: ph_next = PH_MUL0;
				endcase
			end
		end
	end

	// Low-pass filter unit
	gdu_filter #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fctrl),
		.sample (sample_s1),
		.coef   (coef_q),
		.y      (filt_y)
	);

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ph_q     <= PH_MUL0;
		end else begin
			ph_q <= ph_next;
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (item_done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1 <= dec_sample;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// The filter sequencer only leaves its first phase while holding a byte
	a_phase_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != PH_MUL0) |-> valid_s1)
		else $error("filter sequence active without an input byte");

	// Pass-through mode never runs the filter sequence
	a_pass_idle_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(rate_q == gdu_pkg::RATE_PASS) |-> (ph_q == PH_MUL0) && !fctrl.mul && !fctrl.commit)
		else $error("filter sequence active in pass-through mode");

	// A first-of-two sample only appears in double-rate mode
	a_first_only_double: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (rate_q == gdu_pkg::RATE_DOUBLE))
		else $error("non-final sample in pass-through mode");

	// The second filtered sample of a byte follows its multiply phase
	a_last_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(fctrl.commit && ph_q == PH_ADD1) |-> $past(ph_q) == PH_MUL1 || $past(ph_q) == PH_ADD1)
		else $error("second filter commit without its multiply");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the G.711 decoder with 2x upsampling low-pass.
// ----------------------------------------------------------------------------
// Code bytes stream in under several law, rate and coefficient settings. A
// scoreboard decodes each accepted byte, runs the Q15 one-pole filter in
// double-rate mode, and queues the expected samples. Each output transaction
// is checked in order against that queue. Both stream sides idle at random,
// with one phase that runs without any idling.
module testbench;

	localparam int COEF_FRAC_BITS = 15;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 100;
	localparam int IDLE_PCT       = 15;

	localparam int MU_BASE [8] = '{0, 132, 396, 924, 1980, 4092, 8316, 16764};

	// Extremes of the code byte and of each sign, and segment edges
	localparam gdu_pkg::code_t EDGE_CODES [10] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h55,
		8'hD5, 8'h0F, 8'hF0, 8'h7E, 8'hFE};

	typedef struct {
		gdu_pkg::sample_t pcm;
		logic             last;
	} pcm_result_t;

	// Decode and filter model; holds the samples still owed by the block
	class pcm_predictor;
		pcm_result_t    owed_q[$];
		logic           law;
		logic           rate;
		gdu_pkg::coef_t coef;
		longint         acc;
		int             failures;

		function new();
			law      = gdu_pkg::LAW_MU;
			rate     = gdu_pkg::RATE_PASS;
			coef     = gdu_pkg::COEF_RESET;
			acc      = 0;
			failures = 0;
		endfunction

		function void set_config(logic l, logic r, gdu_pkg::coef_t c);
			law  = l;
			rate = r;
			coef = c;
		endfunction

		function int decode_mu(gdu_pkg::code_t b);
			logic [7:0] u;
			int e;
			int m;
			int mag;
			u   = ~b;
			e   = u[6:4];
			m   = u[3:0];
			mag = MU_BASE[e] + (m << (e + 3));
			return u[7] ? -mag : mag;
		endfunction

		function int decode_a(gdu_pkg::code_t b);
			logic [7:0] a;
			int seg;
			int t;
			a   = b ^ 8'h55;
			seg = a[6:4];
			t   = int'(a[3:0]) << 4;
			if (seg == 0) begin
				t = t + 8;
			end else begin
				t = (t + 'h108) << (seg - 1);
			end
			return a[7] ? t : -t;
		endfunction

		// One filter update toward target; truncate and saturate the output
		function gdu_pkg::sample_t filter_step(longint target);
			longint one;
			longint lim;
			longint diff;
			longint y;
			one  = longint'(1) << COEF_FRAC_BITS;
			lim  = longint'(1) << (18 + COEF_FRAC_BITS);
			diff = target * one - acc;
			acc  = acc + (diff * longint'(coef)) / one;
			if (acc > lim - 1) acc = lim - 1;
			if (acc < -lim) acc = -lim;
			y = acc / one;
			if (y > 32767) y = 32767;
			if (y < -32768) y = -32768;
			return gdu_pkg::sample_t'(y);
		endfunction

		function void take_code(gdu_pkg::code_t code);
			int s;
			pcm_result_t r;
			s = (law == gdu_pkg::LAW_A) ? decode_a(code) : decode_mu(code);
			if (rate == gdu_pkg::RATE_PASS) begin
				r.pcm  = gdu_pkg::sample_t'(s);
				r.last = 1'b1;
				owed_q.push_back(r);
			end else begin
				r.pcm  = filter_step(longint'(s) * 2);
				r.last = 1'b0;
				owed_q.push_back(r);
				r.pcm  = filter_step(0);
				r.last = 1'b1;
				owed_q.push_back(r);
			end
		endfunction

		function void check_sample(logic [15:0] data, logic last);
			pcm_result_t r;
			if (owed_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] unexpected sample %0d last %0b", $realtime,
						$signed(data), last);
				return;
			end
			r = owed_q.pop_front();
			if (data !== r.pcm || last !== r.last) begin
				failures++;
				if (failures <= 10)
					$display("[%0t] mismatch: pcm exp %0d act %0d, last exp %0b act %0b",
						$realtime, r.pcm, $signed(data), r.last, last);
			end
		endfunction

		function int owed();
			return owed_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	pcm_predictor sb = new();
	int           idle_pct = IDLE_PCT;
	int           quiet_cycles = 0;

	g711_decode_upsample_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Check each output transaction and stall the output side at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_sample(m_tdata, m_tlast);
		m_tready <= ($urandom_range(99) >= idle_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one code byte, idling at random first; valid stays high afterwards
	task automatic send_code(input gdu_pkg::code_t code);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		do @(posedge clk); while (!s_tready);
		sb.take_code(code);
	endtask

	// Drop valid and wait until every owed sample has left the block
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.owed() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges
	task automatic configure(input logic law, input logic rate,
			input gdu_pkg::coef_t coef);
		cfg_we    <= 1'b1;
		cfg_index <= gdu_pkg::REG_LAW_SELECT;
		cfg_wdata <= {15'd0, law};
		@(posedge clk);
		cfg_index <= gdu_pkg::REG_RATE_MODE;
		cfg_wdata <= {15'd0, rate};
		@(posedge clk);
		cfg_index <= gdu_pkg::REG_FILTER_COEF;
		cfg_wdata <= coef;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(law, rate, coef);
	endtask

	task automatic run_edges(input logic law, input logic rate,
			input gdu_pkg::coef_t coef, input int count);
		configure(law, rate, coef);
		for (int i = 0; i < count; i++)
			send_code(EDGE_CODES[i]);
		drain();
	endtask

	task automatic run_random(input logic law, input logic rate,
			input gdu_pkg::coef_t coef);
		configure(law, rate, coef);
		repeat (PHASE_ITEMS) send_code(gdu_pkg::code_t'($urandom_range(255)));
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= gdu_pkg::REG_LAW_SELECT;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: code byte extremes under both laws, then full-scale filter
		run_edges(gdu_pkg::LAW_MU, gdu_pkg::RATE_PASS, gdu_pkg::COEF_RESET, 10);
		run_edges(gdu_pkg::LAW_A, gdu_pkg::RATE_PASS, gdu_pkg::COEF_RESET, 10);
		run_edges(gdu_pkg::LAW_MU, gdu_pkg::RATE_DOUBLE, 16'd32768, 5);

		// Random content across settings, coefficient extremes included
		run_random(gdu_pkg::LAW_A, gdu_pkg::RATE_DOUBLE, 16'd32768);
		run_random(gdu_pkg::LAW_MU, gdu_pkg::RATE_DOUBLE, 16'd0);
		run_random(gdu_pkg::LAW_A, gdu_pkg::RATE_PASS, 16'd1);
		run_random(gdu_pkg::LAW_MU, gdu_pkg::RATE_DOUBLE, 16'hFFFF);
		run_random(gdu_pkg::LAW_A, gdu_pkg::RATE_DOUBLE, 16'hFFFF);
		run_random(gdu_pkg::LAW_MU, gdu_pkg::RATE_DOUBLE, 16'd1);
		idle_pct = 0;
		run_random(gdu_pkg::LAW_A, gdu_pkg::RATE_DOUBLE, gdu_pkg::COEF_RESET);
		idle_pct = IDLE_PCT;
		run_random(gdu_pkg::LAW_MU, gdu_pkg::RATE_PASS, gdu_pkg::COEF_RESET);
		run_random(gdu_pkg::LAW_MU, gdu_pkg::RATE_DOUBLE, 16'd32767);
		repeat (3)
			run_random(logic'($urandom_range(1)), logic'($urandom_range(1)),
				gdu_pkg::coef_t'($urandom_range(65535)));

		if (sb.failures == 0 && sb.owed() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### g711_decode_upsample_filter.f
rtl/gdu_pkg.sv
rtl/gdu_decode.sv
rtl/gdu_filter.sv
rtl/g711_decode_upsample_filter.sv
verif/testbench.sv
